// ===== hdl/prt_pkg.sv =====
package prt_pkg;

    localparam int PENDING_SLOTS = 16;
    localparam int HISTORY_DEPTH = 64;
    localparam int NUM_COUNTERS  = 6;

    localparam int SEQ_W   = 16;
    localparam int TIME_W  = 32;
    localparam int IDX_W   = 6;
    localparam int KIND_W  = 3;
    localparam int RTT_W   = 16;
    localparam int COUNT_W = 7;
    localparam int VALUE_W = 32;

    localparam int SLOT_W  = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int USED_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int CTR_W   = $clog2(NUM_COUNTERS);
    localparam int HIST_W  = SEQ_W + RTT_W;

    localparam int IN_FIELDS_W  = SEQ_W + TIME_W + IDX_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + RTT_W + 1 + COUNT_W + 1 + SEQ_W + VALUE_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        K_SENT       = 3'd0,
        K_PONG       = 3'd1,
        K_CLEAR_HIST = 3'd2,
        K_RESET_ALL  = 3'd3,
        K_COUNT      = 3'd4,
        K_READ_HIST  = 3'd5,
        K_READ_CTR   = 3'd6
    } t_kind;

    typedef struct packed {
        logic load;
        logic scan;
        logic mem_rd;
        logic commit;
    } t_cmd;

    typedef struct packed {
        t_kind in_kind;
        logic  en;
        logic  scan_stop;
        logic  scan_last;
        logic  out_free;
    } t_sts;

endpackage

// ===== hdl/ping_rtt_tracker_core.sv =====
// Ping round-trip tracker. Each accepted item gives exactly one result item, in order.
// With stats enabled, a sent or pong item walks the 16-entry pending table one slot per
// cycle until a free slot (sent) or a match (pong) is found or the last slot is examined;
// a history read adds a state for the registered history memory read. A result held on
// the output stalls the next result only, so the block takes a new item while the
// previous result waits. No clearing pass is needed after reset. The enable register
// may be written at any idle time and is always ready.
module ping_rtt_tracker_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // seq, now_ms, index
    input  logic [prt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind
    input  logic [prt_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pong_matched, rtt_ms, history_full, history_count, entry_valid, entry_seq,
    // entry_value
    output logic [prt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_data
);

    prt_pkg::t_cmd                 w_cmd;
    prt_pkg::t_sts                 w_sts;
    logic                          w_matched;
    logic [prt_pkg::RTT_W-1:0]     w_rtt;
    logic                          w_full;
    logic [prt_pkg::COUNT_W-1:0]   w_count;
    logic                          w_evalid;
    logic [prt_pkg::SEQ_W-1:0]     w_eseq;
    logic [prt_pkg::VALUE_W-1:0]   w_evalue;

    assign o_cfg_ready = 1'b1;

    prt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    prt_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_kind          (s_axis_tuser),
        .i_seq           (s_axis_tdata[15:0]),
        .i_now_ms        (s_axis_tdata[47:16]),
        .i_index         (s_axis_tdata[53:48]),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_pong_matched  (w_matched),
        .o_rtt_ms        (w_rtt),
        .o_history_full  (w_full),
        .o_history_count (w_count),
        .o_entry_valid   (w_evalid),
        .o_entry_seq     (w_eseq),
        .o_entry_value   (w_evalue)
    );

    assign m_axis_tdata = {
        {(prt_pkg::OUT_TDATA_W - prt_pkg::OUT_FIELDS_W){1'b0}},
        w_evalue, w_eseq, w_evalid, w_count, w_full, w_rtt, w_matched
    };

endmodule

// ===== hdl/prt_ctrl.sv =====
module prt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  prt_pkg::t_sts i_sts,
    output prt_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.en && (i_sts.in_kind == prt_pkg::K_SENT ||
                                     i_sts.in_kind == prt_pkg::K_PONG)) begin
                        n_state = S_SCAN;
                    end else if (i_sts.in_kind == prt_pkg::K_READ_HIST) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_stop || i_sts.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start processing");

    a_scan_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> i_sts.en)
        else $error("table scan while stats disabled");
`endif

endmodule

// ===== hdl/prt_dp.sv =====
module prt_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  prt_pkg::t_cmd                i_cmd,
    output prt_pkg::t_sts                o_sts,
    input  logic [prt_pkg::KIND_W-1:0]   i_kind,
    input  logic [prt_pkg::SEQ_W-1:0]    i_seq,
    input  logic [prt_pkg::TIME_W-1:0]   i_now_ms,
    input  logic [prt_pkg::IDX_W-1:0]    i_index,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_pong_matched,
    output logic [prt_pkg::RTT_W-1:0]    o_rtt_ms,
    output logic                         o_history_full,
    output logic [prt_pkg::COUNT_W-1:0]  o_history_count,
    output logic                         o_entry_valid,
    output logic [prt_pkg::SEQ_W-1:0]    o_entry_seq,
    output logic [prt_pkg::VALUE_W-1:0]  o_entry_value
);

    logic                          r_en;
    prt_pkg::t_kind                r_kind;
    logic [prt_pkg::SEQ_W-1:0]     r_seq;
    logic [prt_pkg::TIME_W-1:0]    r_now;
    logic [prt_pkg::IDX_W-1:0]     r_idx;

    logic [prt_pkg::SLOT_W-1:0]    r_slot;
    logic [prt_pkg::SLOT_W-1:0]    r_victim;
    logic [prt_pkg::TIME_W-1:0]    r_oldest;
    logic                          r_found;
    logic [prt_pkg::RTT_W-1:0]     r_rtt;

    logic [prt_pkg::SEQ_W-1:0]     r_pend_seq  [prt_pkg::PENDING_SLOTS];
    logic [prt_pkg::TIME_W-1:0]    r_pend_time [prt_pkg::PENDING_SLOTS];
    logic [prt_pkg::USED_W-1:0]    r_used;
    logic [prt_pkg::USED_W-1:0]    n_used;
    logic [prt_pkg::VALUE_W-1:0]   r_ctr [prt_pkg::NUM_COUNTERS];

    logic [prt_pkg::HIST_W-1:0]    r_hist [prt_pkg::HISTORY_DEPTH];
    logic [prt_pkg::HIST_W-1:0]    r_hist_q;

    logic                          r_out_valid;
    logic                          r_o_matched;
    logic [prt_pkg::RTT_W-1:0]     r_o_rtt;
    logic                          r_o_full;
    logic [prt_pkg::COUNT_W-1:0]   r_o_count;
    logic                          r_o_evalid;
    logic [prt_pkg::SEQ_W-1:0]     r_o_eseq;
    logic [prt_pkg::VALUE_W-1:0]   r_o_evalue;

    logic [prt_pkg::TIME_W-1:0]    w_time;
    logic [prt_pkg::SEQ_W-1:0]     w_pseq;
    logic [prt_pkg::TIME_W-1:0]    w_diff;
    logic                          w_hit;
    logic                          w_room;
    logic                          w_append;
    logic                          w_ctr_inc;
    logic [prt_pkg::HIST_AW-1:0]   w_rd_addr;
    logic [prt_pkg::HIST_AW-1:0]   w_wr_addr;
    logic [31:0]                   w_used32;

    logic                          n_matched;
    logic [prt_pkg::RTT_W-1:0]     n_rtt;
    logic                          n_full;
    logic                          n_evalid;
    logic [prt_pkg::SEQ_W-1:0]     n_eseq;
    logic [prt_pkg::VALUE_W-1:0]   n_evalue;

    assign w_time    = r_pend_time[r_slot];
    assign w_pseq    = r_pend_seq[r_slot];
    assign w_diff    = r_now - w_time;
    assign w_hit     = (w_time != '0) && (w_pseq == r_seq);
    assign w_room    = 32'(r_used) < 32'(prt_pkg::HISTORY_DEPTH);
    assign w_append  = i_cmd.commit && (r_kind == prt_pkg::K_PONG) && r_found && w_room;
    assign w_ctr_inc = i_cmd.commit && (r_kind == prt_pkg::K_COUNT) && r_en &&
                       (32'(r_idx) < 32'(prt_pkg::NUM_COUNTERS));
    assign w_rd_addr = prt_pkg::HIST_AW'(r_idx);
    assign w_wr_addr = r_used[prt_pkg::HIST_AW-1:0];

    assign o_sts.in_kind   = prt_pkg::t_kind'(i_kind);
    assign o_sts.en        = r_en;
    assign o_sts.scan_stop = (r_kind == prt_pkg::K_SENT) ? (w_time == '0) : w_hit;
    assign o_sts.scan_last = (r_slot == prt_pkg::SLOT_W'(prt_pkg::PENDING_SLOTS - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_used = r_used;
        if (i_cmd.commit && (r_kind == prt_pkg::K_CLEAR_HIST ||
                             r_kind == prt_pkg::K_RESET_ALL)) begin
            n_used = '0;
        end else if (w_append) begin
            n_used = r_used + prt_pkg::USED_W'(1);
        end
    end

    assign w_used32 = 32'(n_used);

    always_comb begin
        n_matched = (r_kind == prt_pkg::K_PONG) && r_found;
        n_rtt     = n_matched ? r_rtt : '0;
        n_full    = n_matched && w_room &&
                    (32'(r_used) + 32'd1 >= 32'(prt_pkg::HISTORY_DEPTH));
        n_evalid  = 1'b0;
        n_eseq    = '0;
        n_evalue  = '0;
        unique case (r_kind)
            prt_pkg::K_READ_HIST: begin
                if (32'(r_idx) < 32'(r_used) &&
                    32'(r_idx) < 32'(prt_pkg::HISTORY_DEPTH)) begin
                    n_evalid = 1'b1;
                    n_eseq   = r_hist_q[prt_pkg::HIST_W-1:prt_pkg::RTT_W];
                    n_evalue = prt_pkg::VALUE_W'(r_hist_q[prt_pkg::RTT_W-1:0]);
                end
            end
            prt_pkg::K_READ_CTR: begin
                if (32'(r_idx) < 32'(prt_pkg::NUM_COUNTERS)) begin
                    n_evalid = 1'b1;
                    n_evalue = r_ctr[r_idx[prt_pkg::CTR_W-1:0]];
                end else if (32'(r_idx) == 32'(prt_pkg::NUM_COUNTERS)) begin
                    n_evalid = 1'b1;
                    n_evalue = r_ctr[0] + r_ctr[1];
                end
            end
            default: begin
                n_evalid = 1'b0;
            end
        endcase
    end

    // item latch and slot scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= prt_pkg::t_kind'(i_kind);
            r_seq    <= i_seq;
            r_now    <= i_now_ms;
            r_idx    <= i_index;
            r_slot   <= '0;
            r_victim <= '0;
            r_oldest <= '1;
        end else if (i_cmd.scan) begin
            r_slot <= r_slot + prt_pkg::SLOT_W'(1);
            if (r_kind == prt_pkg::K_SENT) begin
                if (w_time == '0) begin
                    r_victim <= r_slot;
                end else if (w_time < r_oldest) begin
                    r_oldest <= w_time;
                    r_victim <= r_slot;
                end
            end else if (w_hit) begin
                r_victim <= r_slot;
                r_rtt    <= w_diff[prt_pkg::RTT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load || i_cmd.commit) begin
            r_found <= 1'b0;
        end else if (i_cmd.scan && r_kind == prt_pkg::K_PONG && w_hit) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= 1'b0;
        end else if (i_cfg_valid) begin
            r_en <= i_cfg_data;
        end
    end

    // pending table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < prt_pkg::PENDING_SLOTS; i++) begin
                r_pend_time[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (r_kind == prt_pkg::K_RESET_ALL) begin
                for (int i = 0; i < prt_pkg::PENDING_SLOTS; i++) begin
                    r_pend_time[i] <= '0;
                end
            end else if (r_kind == prt_pkg::K_SENT && r_en) begin
                r_pend_time[r_victim] <= r_now;
            end else if (r_kind == prt_pkg::K_PONG && r_found) begin
                r_pend_time[r_victim] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_kind == prt_pkg::K_SENT && r_en) begin
            r_pend_seq[r_victim] <= r_seq;
        end
    end

    // history store
    always_ff @(posedge i_clk) begin
        if (w_append) begin
            r_hist[w_wr_addr] <= {r_seq, r_rtt};
        end
        if (i_cmd.mem_rd) begin
            r_hist_q <= r_hist[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    // event counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < prt_pkg::NUM_COUNTERS; i++) begin
                r_ctr[i] <= '0;
            end
        end else if (i_cmd.commit && r_kind == prt_pkg::K_RESET_ALL) begin
            for (int i = 0; i < prt_pkg::NUM_COUNTERS; i++) begin
                r_ctr[i] <= '0;
            end
        end else if (w_ctr_inc) begin
            r_ctr[r_idx[prt_pkg::CTR_W-1:0]] <= r_ctr[r_idx[prt_pkg::CTR_W-1:0]] + 32'd1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_matched <= n_matched;
            r_o_rtt     <= n_rtt;
            r_o_full    <= n_full;
            r_o_count   <= w_used32[prt_pkg::COUNT_W-1:0];
            r_o_evalid  <= n_evalid;
            r_o_eseq    <= n_eseq;
            r_o_evalue  <= n_evalue;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pong_matched  = r_o_matched;
    assign o_rtt_ms        = r_o_rtt;
    assign o_history_full  = r_o_full;
    assign o_history_count = r_o_count;
    assign o_entry_valid   = r_o_evalid;
    assign o_entry_seq     = r_o_eseq;
    assign o_entry_value   = r_o_evalue;

`ifndef SYNTH
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_used) <= 32'(prt_pkg::HISTORY_DEPTH))
        else $error("history fill count past depth");

    a_found_is_pong: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_kind == prt_pkg::K_PONG && r_en))
        else $error("match flag set outside an enabled pong");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

// ===== sim/ping_rtt_tracker_core_tb.sv =====
`timescale 1ns / 1ps

module ping_rtt_tracker_core_tb;

    localparam int RUN_LIMIT = 2000000;

    typedef struct packed {
        logic [prt_pkg::VALUE_W-1:0] value;
        logic [prt_pkg::SEQ_W-1:0]   eseq;
        logic                        valid;
        logic [prt_pkg::COUNT_W-1:0] count;
        logic                        full;
        logic [prt_pkg::RTT_W-1:0]   rtt;
        logic                        matched;
    } t_rtt_report;

    class t_rtt_scoreboard;
        logic [prt_pkg::SEQ_W-1:0]   slot_seq [prt_pkg::PENDING_SLOTS];
        logic [prt_pkg::TIME_W-1:0]  slot_time[prt_pkg::PENDING_SLOTS];
        logic [prt_pkg::SEQ_W-1:0]   hist_seq [prt_pkg::HISTORY_DEPTH];
        logic [prt_pkg::RTT_W-1:0]   hist_rtt [prt_pkg::HISTORY_DEPTH];
        logic [prt_pkg::COUNT_W-1:0] hist_used;
        logic [prt_pkg::VALUE_W-1:0] counters [prt_pkg::NUM_COUNTERS];
        bit                          enable;
        t_rtt_report                 reports_due[$];
        int                          mismatches;

        function new();
            clear_tables();
            foreach (hist_seq[i]) begin
                hist_seq[i] = '0;
                hist_rtt[i] = '0;
            end
            enable     = 1'b0;
            mismatches = 0;
        endfunction

        function void clear_tables();
            foreach (slot_seq[i]) begin
                slot_seq[i]  = '0;
                slot_time[i] = '0;
            end
            foreach (counters[i]) counters[i] = '0;
            hist_used = '0;
        endfunction

        function int waiting();
            return reports_due.size();
        endfunction

        function void note_item(logic [prt_pkg::KIND_W-1:0] kind,
                                logic [prt_pkg::SEQ_W-1:0] seq,
                                logic [prt_pkg::TIME_W-1:0] now,
                                logic [prt_pkg::IDX_W-1:0] idx);
            t_rtt_report                rep;
            logic [prt_pkg::TIME_W-1:0] oldest;
            logic [prt_pkg::TIME_W-1:0] diff;
            int                         victim;
            bit                         found;
            int                         i;
            rep = '0;
            case (kind)
                prt_pkg::K_SENT: if (enable) begin
                    oldest = '1;
                    victim = 0;
                    found  = 1'b0;
                    for (i = 0; i < prt_pkg::PENDING_SLOTS; i++) begin
                        if (!found) begin
                            if (slot_time[i] == '0) begin
                                victim = i;
                                found  = 1'b1;
                            end else if (slot_time[i] < oldest) begin
                                oldest = slot_time[i];
                                victim = i;
                            end
                        end
                    end
                    slot_seq[victim]  = seq;
                    slot_time[victim] = now;
                end
                prt_pkg::K_PONG: if (enable) begin
                    found = 1'b0;
                    for (i = 0; i < prt_pkg::PENDING_SLOTS; i++) begin
                        if (!found && slot_time[i] != '0 && slot_seq[i] == seq) begin
                            found       = 1'b1;
                            diff        = now - slot_time[i];
                            rep.matched = 1'b1;
                            rep.rtt     = diff[prt_pkg::RTT_W-1:0];
                            if (hist_used < prt_pkg::HISTORY_DEPTH) begin
                                hist_seq[hist_used] = seq;
                                hist_rtt[hist_used] = diff[prt_pkg::RTT_W-1:0];
                                hist_used = hist_used + prt_pkg::COUNT_W'(1);
                                if (hist_used >= prt_pkg::HISTORY_DEPTH) rep.full = 1'b1;
                            end
                            slot_time[i] = '0;
                        end
                    end
                end
                prt_pkg::K_CLEAR_HIST: hist_used = '0;
                prt_pkg::K_RESET_ALL:  clear_tables();
                prt_pkg::K_COUNT: if (enable && idx < prt_pkg::NUM_COUNTERS) begin
                    counters[idx] = counters[idx] + 32'd1;
                end
                prt_pkg::K_READ_HIST: if (idx < hist_used && idx < prt_pkg::HISTORY_DEPTH) begin
                    rep.valid                     = 1'b1;
                    rep.eseq                      = hist_seq[idx];
                    rep.value[prt_pkg::RTT_W-1:0] = hist_rtt[idx];
                end
                prt_pkg::K_READ_CTR: if (idx < prt_pkg::NUM_COUNTERS) begin
                    rep.valid = 1'b1;
                    rep.value = counters[idx];
                end else if (idx == prt_pkg::NUM_COUNTERS) begin
                    rep.valid = 1'b1;
                    rep.value = counters[0] + counters[1];
                end
                default: ;
            endcase
            rep.count = hist_used;
            reports_due.push_back(rep);
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch %s: expected %0h, got %0h", what, want, got);
            end
        endfunction

        function void cmp(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) flag(what, want, got);
        endfunction

        function void check_item(logic [prt_pkg::OUT_TDATA_W-1:0] word);
            t_rtt_report got;
            t_rtt_report want;
            got = word[prt_pkg::OUT_FIELDS_W-1:0];
            if (reports_due.size() == 0) begin
                flag("result item with nothing pending", 32'd0, 32'd1);
                return;
            end
            want = reports_due.pop_front();
            cmp("pong_matched", 32'(want.matched), 32'(got.matched));
            cmp("rtt_ms", 32'(want.rtt), 32'(got.rtt));
            cmp("history_full", 32'(want.full), 32'(got.full));
            cmp("history_count", 32'(want.count), 32'(got.count));
            cmp("entry_valid", 32'(want.valid), 32'(got.valid));
            cmp("entry_seq", 32'(want.eseq), 32'(got.eseq));
            cmp("entry_value", want.value, got.value);
            cmp("tdata pad", 32'd0,
                32'(word[prt_pkg::OUT_TDATA_W-1:prt_pkg::OUT_FIELDS_W]));
        endfunction
    endclass

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [prt_pkg::IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [prt_pkg::KIND_W-1:0]       s_axis_tuser  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [prt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                             i_cfg_valid   = 1'b0;
    logic                             o_cfg_ready;
    logic                             i_cfg_data    = 1'b0;

    t_rtt_scoreboard                  tracker;
    bit                               no_idle       = 1'b0;
    bit                               hold_request  = 1'b0;
    logic [prt_pkg::TIME_W-1:0]       ms_now        = 32'd1;
    logic [prt_pkg::SEQ_W-1:0]        recent[$];

    ping_rtt_tracker_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [prt_pkg::TIME_W-1:0] tick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)      ms_now = ms_now + $urandom_range(1, 20);
        else if (r < 78) ms_now = ms_now;
        else if (r < 94) ms_now = ms_now + $urandom_range(21, 3000);
        else if (r < 99) ms_now = $urandom();
        else             ms_now = '0;
        return ms_now;
    endfunction

    function automatic logic [prt_pkg::SEQ_W-1:0] rand_seq();
        return prt_pkg::SEQ_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [prt_pkg::IDX_W-1:0] rand_idx(int top);
        return prt_pkg::IDX_W'($urandom_range(0, top));
    endfunction

    function automatic logic [prt_pkg::SEQ_W-1:0] fresh_seq();
        if ($urandom_range(0, 99) < 15) return prt_pkg::SEQ_W'($urandom_range(0, 7));
        return rand_seq();
    endfunction

    function automatic void remember(logic [prt_pkg::SEQ_W-1:0] s);
        recent.push_back(s);
        if (recent.size() > 32) void'(recent.pop_front());
    endfunction

    task automatic send_item(input logic [prt_pkg::KIND_W-1:0] kind,
                             input logic [prt_pkg::SEQ_W-1:0] seq,
                             input logic [prt_pkg::TIME_W-1:0] now,
                             input logic [prt_pkg::IDX_W-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(prt_pkg::IN_TDATA_W-prt_pkg::IN_FIELDS_W){1'b0}}, idx, now, seq};
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_item(kind, seq, now, idx);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (tracker.waiting() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_enable(input bit en);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= en;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tracker.enable = en;
    endtask

    task automatic run_phase(input int target, input int clear_odds, input int reset_odds);
        int                         sent_items;
        int                         pick;
        int                         n;
        int                         j;
        int                         r;
        logic [prt_pkg::SEQ_W-1:0]  s;
        logic [prt_pkg::TIME_W-1:0] t;
        logic [prt_pkg::IDX_W-1:0]  idx;
        logic [prt_pkg::SEQ_W-1:0]  open_seqs[$];
        sent_items = 0;
        while (sent_items < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                n = $urandom_range(1, 5);
                open_seqs.delete();
                repeat (n) begin
                    s = fresh_seq();
                    open_seqs.push_back(s);
                    remember(s);
                    send_item(prt_pkg::K_SENT, s, tick(), rand_idx(63));
                end
                while (open_seqs.size() > 0) begin
                    j = $urandom_range(0, open_seqs.size() - 1);
                    s = open_seqs[j];
                    open_seqs.delete(j);
                    if ($urandom_range(0, 9) == 0) s = rand_seq();
                    send_item(prt_pkg::K_PONG, s, tick(), rand_idx(63));
                end
                sent_items += 2 * n;
            end else if (pick < 63) begin
                // flood the pending table so the oldest slot gets replaced
                n = $urandom_range(prt_pkg::PENDING_SLOTS + 1, prt_pkg::PENDING_SLOTS + 4);
                t = tick();
                r = $urandom_range(0, 1);
                repeat (n) begin
                    s = fresh_seq();
                    remember(s);
                    send_item(prt_pkg::K_SENT, s, r ? t : t + $urandom_range(0, 2),
                              rand_idx(63));
                end
                sent_items += n;
            end else if (pick < 73) begin
                idx = ($urandom_range(0, 9) < 8) ? rand_idx(6) : rand_idx(63);
                send_item(prt_pkg::K_COUNT, rand_seq(), tick(), idx);
                sent_items++;
            end else if (pick < 83) begin
                if (tracker.hist_used > 0 && $urandom_range(0, 9) < 7)
                    idx = rand_idx(int'(tracker.hist_used) - 1);
                else
                    idx = rand_idx(63);
                send_item(prt_pkg::K_READ_HIST, rand_seq(), tick(), idx);
                sent_items++;
            end else if (pick < 93) begin
                idx = ($urandom_range(0, 9) < 8) ? rand_idx(7) : rand_idx(63);
                send_item(prt_pkg::K_READ_CTR, rand_seq(), tick(), idx);
                sent_items++;
            end else if (pick < 97) begin
                if (recent.size() > 0 && $urandom_range(0, 1))
                    s = recent[$urandom_range(0, recent.size() - 1)];
                else
                    s = rand_seq();
                send_item($urandom_range(0, 1) ? prt_pkg::K_PONG : prt_pkg::K_SENT, s, tick(),
                          rand_idx(63));
                sent_items++;
            end else begin
                r = $urandom_range(0, 99);
                if (r < clear_odds)
                    send_item(prt_pkg::K_CLEAR_HIST, rand_seq(), tick(), rand_idx(63));
                else if (r < clear_odds + reset_odds)
                    send_item(prt_pkg::K_RESET_ALL, rand_seq(), tick(), rand_idx(63));
                else
                    send_item(prt_pkg::K_READ_CTR, rand_seq(), tick(),
                              prt_pkg::IDX_W'(prt_pkg::NUM_COUNTERS));
                sent_items++;
            end
        end
    endtask

    initial begin : sink
        int low_left;
        low_left = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) tracker.check_item(m_axis_tdata);
            if (hold_request) begin
                hold_request = 1'b0;
                low_left     = 400;
            end
            if (low_left > 0) begin
                m_axis_tready <= 1'b0;
                low_left--;
            end else begin
                m_axis_tready <= 1'b1;
                low_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        tracker = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_enable(1'b0);
        send_item(prt_pkg::K_SENT, 16'd1, 32'd100, 6'd0);
        send_item(prt_pkg::K_PONG, 16'd1, 32'd150, 6'd0);
        send_item(prt_pkg::K_COUNT, 16'd0, 32'd160, 6'd0);

        write_enable(1'b1);
        send_item(prt_pkg::K_SENT, 16'd0, 32'd0, 6'd0);
        send_item(prt_pkg::K_PONG, 16'd0, 32'd10, 6'd0);
        send_item(prt_pkg::K_SENT, 16'hFFFF, 32'hFFFF_FFFF, 6'h3F);
        send_item(prt_pkg::K_PONG, 16'hFFFF, 32'd4, 6'h3F);
        send_item(prt_pkg::K_PONG, 16'd1234, 32'd20, 6'd0);
        send_item(prt_pkg::K_COUNT, 16'd0, 32'd30, 6'd0);
        send_item(prt_pkg::K_COUNT, 16'd0, 32'd30, 6'd1);
        send_item(prt_pkg::K_COUNT, 16'd0, 32'd30, 6'd5);
        send_item(prt_pkg::K_COUNT, 16'd0, 32'd30, 6'h3F);
        send_item(prt_pkg::K_READ_CTR, 16'd0, 32'd40, 6'd0);
        send_item(prt_pkg::K_READ_CTR, 16'd0, 32'd40, 6'd6);
        send_item(prt_pkg::K_READ_CTR, 16'd0, 32'd40, 6'd7);
        send_item(prt_pkg::K_READ_CTR, 16'd0, 32'd40, 6'h3F);
        send_item(prt_pkg::K_READ_HIST, 16'd0, 32'd50, 6'd0);
        send_item(prt_pkg::K_READ_HIST, 16'd0, 32'd50, 6'd1);
        send_item(prt_pkg::K_READ_HIST, 16'd0, 32'd50, 6'h3F);
        send_item(prt_pkg::K_CLEAR_HIST, 16'd0, 32'd60, 6'd0);
        send_item(prt_pkg::K_READ_HIST, 16'd0, 32'd60, 6'd0);
        send_item(prt_pkg::K_RESET_ALL, 16'd0, 32'd70, 6'd0);
        send_item(prt_pkg::K_READ_CTR, 16'd0, 32'd70, 6'd0);

        run_phase(100, 0, 0);
        hold_request = 1'b1;
        run_phase(200, 0, 0);

        write_enable(1'b0);
        run_phase(60, 30, 10);

        write_enable(1'b1);
        run_phase(250, 40, 15);

        wait_drained();
        no_idle = 1'b1;
        run_phase(200, 20, 5);
        no_idle = 1'b0;

        write_enable(1'b0);
        run_phase(40, 20, 10);
        write_enable(1'b1);
        run_phase(50, 10, 5);

        wait_drained();
        if (tracker.mismatches == 0 && tracker.waiting() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
